// ===== hdl/mipfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mipfb_pkg
// Shared types, byte codes and helpers for the memory-in-pixel LCD
// frame buffer serialiser.
// ----------------------------------------------------------------------------
package mipfb_pkg;

    localparam int WIDTH_BYTES_DEF = 16;
    localparam int HEIGHT_DEF      = 128;

    localparam logic [7:0] CMD_CLEAR_P1 = 8'b0110_0000;
    localparam logic [7:0] CMD_CLEAR_P0 = 8'b0010_0000;
    localparam logic [7:0] CMD_VCOM_P1  = 8'b0100_0000;
    localparam logic [7:0] CMD_VCOM_P0  = 8'b0000_0000;
    localparam logic [7:0] CMD_WRITE_P1 = 8'b1100_0000;
    localparam logic [7:0] CMD_WRITE_P0 = 8'b1000_0000;
    localparam logic [7:0] BYTE_ZERO    = 8'b0000_0000;
    localparam logic [7:0] BYTE_WHITE   = 8'b1111_1111;

    typedef enum logic [2:0] {
        KIND_DRAW    = 3'd0,
        KIND_ERASE   = 3'd1,
        KIND_CLEAR   = 3'd2,
        KIND_TOGGLE  = 3'd3,
        KIND_REFRESH = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FILL,
        S_RMW_RD,
        S_RMW_WR,
        S_CMD,
        S_ADDR,
        S_DATA,
        S_TRAIL,
        S_CLOSE
    } state_t;

    typedef enum logic [1:0] {
        SRC_CMD,
        SRC_ADDR,
        SRC_DATA,
        SRC_ZERO
    } src_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       first;
        logic       last;
        logic       row_ok;
        logic       pix_ok;
        logic       row_valid;
        logic       out_free;
        logic       cnt_last;
        logic       cnt_full;
    } seq_status_t;

    typedef struct packed {
        logic in_ready;
        logic rd_en;
        logic wr_en;
        logic wr_fill;
        logic use_col;
        logic emit;
        src_t src;
        logic frame_end;
        logic phase_flip;
        logic rowv_set;
        logic rowv_clr_all;
        logic cnt_clr;
        logic cnt_inc;
    } seq_ctrl_t;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

// ===== hdl/mip_lcd_framebuffer_serializer.sv =====
// ----------------------------------------------------------------------------
// mip_lcd_framebuffer_serializer
// One-bit frame buffer with pixel draw/erase, clear, VCOM toggle and
// line refresh, serialised as a byte stream for the display.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_ready is high only between requests.
// A line refresh streams one byte per cycle, while the output accepts, through
// a single buffer read port: after the dispatch state it sends up to
// WIDTH_BYTES+4 bytes. Clear and VCOM toggle send a command byte and then
// the closing byte. A draw or erase is a read-modify-write of one buffer
// byte, preceded by a white fill of the row's WIDTH_BYTES bytes when the row
// has not been written since reset or the last clear. Rows are tracked by one
// valid flag each, so reset and clear take effect at once with no clearing
// pass. Output stalls hold the sequencer at the byte being presented.
// ----------------------------------------------------------------------------
module mip_lcd_framebuffer_serializer
    import mipfb_pkg::*;
#(
    parameter int WIDTH_BYTES = WIDTH_BYTES_DEF,
    parameter int HEIGHT      = HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] kind,
    input  logic [6:0] pixel_column,
    input  logic [6:0] row,
    input  logic       first_line,
    input  logic       last_line,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] spi_byte,
    output logic       frame_end
);

    localparam int DEPTH = WIDTH_BYTES * HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(WIDTH_BYTES + 1);
    localparam int RW    = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;

    seq_status_t status;
    seq_ctrl_t   ctrl;

    logic [2:0]        kind_reg;
    logic [6:0]        col_reg;
    logic [6:0]        row_reg;
    logic              first_reg;
    logic              last_reg;
    logic [CW-1:0]     cnt_reg;
    logic [HEIGHT-1:0] row_valid_reg;
    logic              vcom_phase_reg;
    logic              out_valid_reg;
    logic [7:0]        spi_byte_reg;
    logic              frame_end_reg;

    logic [8:0]    row_ext;
    logic [RW-1:0] rix;
    logic          row_ok;
    logic          pix_ok;
    logic          row_valid;
    logic [AW-1:0] base;
    logic [AW-1:0] offset;
    logic [AW-1:0] addr;
    logic [7:0]    rd_data;
    logic [7:0]    pix_mask;
    logic [7:0]    wr_data;
    logic [7:0]    cmd_byte;
    logic [7:0]    data_byte;
    logic [7:0]    byte_next;
    logic          out_free;

    assign row_ext   = {2'b00, row_reg};
    assign rix       = row_ext[RW-1:0];
    assign row_ok    = (row_ext < 9'(HEIGHT));
    assign pix_ok    = row_ok && (6'({2'b00, col_reg[6:3]}) < 6'(WIDTH_BYTES));
    assign row_valid = row_valid_reg[rix];
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        status           = '0;
        status.kind      = kind_reg;
        status.first     = first_reg;
        status.last      = last_reg;
        status.row_ok    = row_ok;
        status.pix_ok    = pix_ok;
        status.row_valid = row_valid;
        status.out_free  = out_free;
        status.cnt_last  = (cnt_reg == CW'(WIDTH_BYTES - 1));
        status.cnt_full  = (cnt_reg == CW'(WIDTH_BYTES));
    end

    mipfb_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    assign in_ready = ctrl.in_ready;

    // Shared address unit: row base plus byte offset.
    assign base   = AW'(row_ext) * AW'(WIDTH_BYTES);
    assign offset = ctrl.use_col ? AW'(col_reg[6:3]) : AW'(cnt_reg);
    assign addr   = base + offset;

    assign pix_mask = 8'(1) << col_reg[2:0];

    always_comb
    begin
        if (ctrl.wr_fill)
        begin
            wr_data = BYTE_WHITE;
        end
        else if (kind_reg == KIND_ERASE)
        begin
            wr_data = rd_data | pix_mask;
        end
        else
        begin
            wr_data = rd_data & ~pix_mask;
        end
    end

    mipfb_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (kind_reg)
            KIND_CLEAR:  cmd_byte = vcom_phase_reg ? CMD_CLEAR_P1 : CMD_CLEAR_P0;
            KIND_TOGGLE: cmd_byte = vcom_phase_reg ? CMD_VCOM_P1 : CMD_VCOM_P0;
            default:     cmd_byte = vcom_phase_reg ? CMD_WRITE_P1 : CMD_WRITE_P0;
        endcase
    end

    assign data_byte = row_valid ? rd_data : BYTE_WHITE;

    always_comb
    begin
        case (ctrl.src)
            SRC_CMD:  byte_next = cmd_byte;
            SRC_ADDR: byte_next = reverse8(row_ext[7:0]);
            SRC_DATA: byte_next = data_byte;
            default:  byte_next = BYTE_ZERO;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ctrl.in_ready)
        begin
            kind_reg  <= kind;
            col_reg   <= pixel_column;
            row_reg   <= row;
            first_reg <= first_line;
            last_reg  <= last_line;
        end
        if (ctrl.emit)
        begin
            spi_byte_reg  <= byte_next;
            frame_end_reg <= ctrl.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            row_valid_reg  <= '0;
            vcom_phase_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (ctrl.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (ctrl.rowv_clr_all)
            begin
                row_valid_reg <= '0;
            end
            else if (ctrl.rowv_set)
            begin
                row_valid_reg[rix] <= 1'b1;
            end
            if (ctrl.phase_flip)
            begin
                vcom_phase_reg <= !vcom_phase_reg;
            end
            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign spi_byte  = spi_byte_reg;
    assign frame_end = frame_end_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> (!out_valid_reg || out_ready))
        else $error("byte loaded over an unaccepted byte");

    a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> (spi_byte == BYTE_ZERO))
        else $error("closing byte is not zero");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while previous one not started");

    a_clear_rows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rowv_clr_all |=> (row_valid_reg == '0))
        else $error("row flags not cleared");
`endif

endmodule

// ===== hdl/mipfb_ram.sv =====
// ----------------------------------------------------------------------------
// mipfb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mipfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                         wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mipfb_seq.sv =====
// ----------------------------------------------------------------------------
// mipfb_seq
// Request sequencer: steps one request through fill, read-modify-write and
// the byte sequence of a transfer.
// ----------------------------------------------------------------------------
module mipfb_seq
    import mipfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  seq_status_t status,
    output seq_ctrl_t   ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    KIND_DRAW, KIND_ERASE:
                    begin
                        if (!status.pix_ok)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (status.row_valid)
                        begin
                            state_next = S_RMW_RD;
                        end
                        else
                        begin
                            state_next = S_FILL;
                        end
                    end
                    KIND_CLEAR, KIND_TOGGLE:
                    begin
                        state_next = S_CMD;
                    end
                    KIND_REFRESH:
                    begin
                        if (status.first)
                        begin
                            state_next = S_CMD;
                        end
                        else if (status.row_ok)
                        begin
                            state_next = S_ADDR;
                        end
                        else if (status.last)
                        begin
                            state_next = S_CLOSE;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FILL:
            begin
                if (status.cnt_last)
                begin
                    state_next = S_RMW_RD;
                end
            end
            S_RMW_RD:
            begin
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                state_next = S_IDLE;
            end
            S_CMD:
            begin
                if (status.out_free)
                begin
                    if (status.kind != KIND_REFRESH)
                    begin
                        state_next = S_CLOSE;
                    end
                    else if (status.row_ok)
                    begin
                        state_next = S_ADDR;
                    end
                    else if (status.last)
                    begin
                        state_next = S_CLOSE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ADDR:
            begin
                if (status.out_free)
                begin
                    state_next = S_DATA;
                end
            end
            S_DATA:
            begin
                if (status.out_free && status.cnt_full)
                begin
                    state_next = S_TRAIL;
                end
            end
            S_TRAIL:
            begin
                if (status.out_free)
                begin
                    state_next = status.last ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.src = SRC_ZERO;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            S_DISPATCH:
            begin
                ctrl.cnt_clr = 1'b1;
                ctrl.rowv_clr_all = (status.kind == KIND_CLEAR);
            end
            S_FILL:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_fill = 1'b1;
                ctrl.cnt_inc = 1'b1;
                if (status.cnt_last)
                begin
                    ctrl.rowv_set = 1'b1;
                    ctrl.cnt_clr  = 1'b1;
                end
            end
            S_RMW_RD:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.use_col = 1'b1;
            end
            S_RMW_WR:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.use_col = 1'b1;
            end
            S_CMD:
            begin
                ctrl.src = SRC_CMD;
                if (status.out_free)
                begin
                    ctrl.emit       = 1'b1;
                    ctrl.phase_flip = 1'b1;
                end
            end
            S_ADDR:
            begin
                ctrl.src = SRC_ADDR;
                if (status.out_free)
                begin
                    ctrl.emit    = 1'b1;
                    ctrl.rd_en   = 1'b1;
                    ctrl.cnt_inc = 1'b1;
                end
            end
            S_DATA:
            begin
                ctrl.src = SRC_DATA;
                if (status.out_free)
                begin
                    ctrl.emit = 1'b1;
                    if (!status.cnt_full)
                    begin
                        ctrl.rd_en   = 1'b1;
                        ctrl.cnt_inc = 1'b1;
                    end
                end
            end
            S_TRAIL:
            begin
                ctrl.emit = status.out_free;
            end
            S_CLOSE:
            begin
                ctrl.emit      = status.out_free;
                ctrl.frame_end = 1'b1;
            end
            default:
            begin
                ctrl.src = SRC_ZERO;
            end
        endcase
    end

endmodule

// ===== tb/tb_mip_lcd_framebuffer_serializer.sv =====
// ----------------------------------------------------------------------------
// tb_mip_lcd_framebuffer_serializer
// Self-checking bench for the memory-in-pixel LCD frame buffer serialiser.
// A queue of requests feeds a valid/ready driver that keeps a shadow frame
// buffer and VCOM phase and predicts every SPI byte. A monitor with random
// back-pressure compares each byte and frame end flag in order. A directed
// opening is followed by random requests of every kind, unused codes too.
// ----------------------------------------------------------------------------
module tb_mip_lcd_framebuffer_serializer;

    import mipfb_pkg::*;

    localparam int FB_W          = WIDTH_BYTES_DEF;
    localparam int FB_H          = HEIGHT_DEF;
    localparam int FB_BYTES      = FB_W * FB_H;
    localparam int HOLD_TRIGGER  = 300;
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_CYCLES  = 100;
    localparam int TARGET_ITEMS  = 150;
    localparam int LIMIT_CYCLES  = 1000000;

    typedef struct {
        logic [2:0] kind;
        logic [6:0] col;
        logic [6:0] row;
        logic       first;
        logic       last;
        bit         settle;
    } lcd_request_t;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } spi_word_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [2:0] kind         = '0;
    logic [6:0] pixel_column = '0;
    logic [6:0] row          = '0;
    logic       first_line   = 1'b0;
    logic       last_line    = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] spi_byte;
    logic       frame_end;

    lcd_request_t pending[$];
    spi_word_t    spi_expected[$];
    lcd_request_t cur_req;
    logic [7:0]   fb_shadow [0:FB_BYTES-1];
    logic         vcom_shadow;

    bit  offering;
    int  send_gap;
    int  send_calm;
    int  predicted_count;
    int  recv_gap;
    int  recv_calm;
    int  results_seen;
    int  failures;
    int  made;
    logic ready_next;
    spi_word_t want;

    bit  holding;
    bit  hold_done;
    int  hold_left;

    mip_lcd_framebuffer_serializer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .pixel_column (pixel_column),
        .row          (row),
        .first_line   (first_line),
        .last_line    (last_line),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .spi_byte     (spi_byte),
        .frame_end    (frame_end)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_spi(input logic [7:0] data, input logic fin);
        spi_word_t w;
        w.data = data;
        w.fin  = fin;
        spi_expected.push_back(w);
        predicted_count++;
    endfunction

    task automatic predict_spi_bytes(input lcd_request_t r);
        int         idx;
        int         i;
        logic [7:0] mask;
        logic [7:0] addr;
        logic [7:0] rev;
        case (r.kind)
            KIND_DRAW, KIND_ERASE:
            begin
                if (int'(r.row) < FB_H && int'(r.col[6:3]) < FB_W)
                begin
                    idx  = int'(r.row) * FB_W + int'(r.col[6:3]);
                    mask = 8'h01 << r.col[2:0];
                    if (r.kind == KIND_DRAW)
                        fb_shadow[idx] = fb_shadow[idx] & ~mask;
                    else
                        fb_shadow[idx] = fb_shadow[idx] | mask;
                end
            end
            KIND_CLEAR:
            begin
                for (i = 0; i < FB_BYTES; i++)
                    fb_shadow[i] = BYTE_WHITE;
                push_spi(vcom_shadow ? CMD_CLEAR_P1 : CMD_CLEAR_P0, 1'b0);
                vcom_shadow = ~vcom_shadow;
                push_spi(BYTE_ZERO, 1'b1);
            end
            KIND_TOGGLE:
            begin
                push_spi(vcom_shadow ? CMD_VCOM_P1 : CMD_VCOM_P0, 1'b0);
                vcom_shadow = ~vcom_shadow;
                push_spi(BYTE_ZERO, 1'b1);
            end
            KIND_REFRESH:
            begin
                if (r.first)
                begin
                    push_spi(vcom_shadow ? CMD_WRITE_P1 : CMD_WRITE_P0, 1'b0);
                    vcom_shadow = ~vcom_shadow;
                end
                if (int'(r.row) < FB_H)
                begin
                    addr = {1'b0, r.row};
                    for (i = 0; i < 8; i++)
                        rev[7 - i] = addr[i];
                    push_spi(rev, 1'b0);
                    for (i = 0; i < FB_W; i++)
                        push_spi(fb_shadow[int'(r.row) * FB_W + i], 1'b0);
                    push_spi(BYTE_ZERO, 1'b0);
                end
                if (r.last)
                    push_spi(BYTE_ZERO, 1'b1);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_request(input logic [2:0] k, input int c, input int r,
                                 input bit f, input bit l, input bit s);
        lcd_request_t q;
        q.kind   = k;
        q.col    = c[6:0];
        q.row    = r[6:0];
        q.first  = f;
        q.last   = l;
        q.settle = s;
        pending.push_back(q);
        made++;
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            send_gap = 0;
            send_calm = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_spi_bytes(cur_req);
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending.size() > 0 &&
                         !(pending[0].settle && predicted_count > results_seen))
                begin
                    cur_req = pending.pop_front();
                    offering = 1'b1;
                    kind         <= cur_req.kind;
                    pixel_column <= cur_req.col;
                    row          <= cur_req.row;
                    first_line   <= cur_req.first;
                    last_line    <= cur_req.last;
                    send_gap = pick_gap(send_calm);
                end
            end
            in_valid <= offering;
        end
    end

    // Long receiver hold-off, so that the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding   <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end
        else if (!hold_done && results_seen >= HOLD_TRIGGER)
        begin
            holding   <= 1'b1;
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (holding)
        begin
            if (hold_left <= 1)
                holding <= 1'b0;
            hold_left <= hold_left - 1;
        end
    end

    // Byte monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            results_seen <= 0;
            recv_gap = 0;
            recv_calm = 0;
        end
        else
        begin
            ready_next = 1'b1;
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (spi_expected.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected byte %02h end %0b at %0t",
                                 spi_byte, frame_end, $time);
                end
                else
                begin
                    want = spi_expected.pop_front();
                    if (spi_byte !== want.data || frame_end !== want.fin)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("byte %0d: expected %02h end %0b, got %02h end %0b",
                                     results_seen, want.data, want.fin,
                                     spi_byte, frame_end);
                    end
                end
                recv_gap = pick_gap(recv_calm);
            end
            if (holding)
                ready_next = 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                ready_next = 1'b0;
            end
            out_ready <= ready_next;
        end
    end

    initial
    begin
        #(12 * LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int  i;
        int  sel;
        int  hot;
        int  lines;
        int  j;
        for (i = 0; i < FB_BYTES; i++)
            fb_shadow[i] = BYTE_WHITE;
        vcom_shadow = 1'b0;
        predicted_count = 0;
        failures = 0;
        made = 0;

        // Directed opening
        queue_request(KIND_REFRESH, 0, 0, 1, 1, 0);
        queue_request(KIND_DRAW, 0, 0, 0, 0, 0);
        queue_request(KIND_DRAW, 127, 127, 1, 1, 0);
        queue_request(KIND_DRAW, 7, 0, 0, 0, 0);
        queue_request(KIND_DRAW, 8, 64, 0, 0, 0);
        queue_request(KIND_DRAW, 85, 42, 1, 0, 0);
        queue_request(KIND_REFRESH, 127, 0, 1, 0, 0);
        queue_request(KIND_REFRESH, 0, 127, 0, 0, 0);
        queue_request(KIND_REFRESH, 64, 64, 0, 1, 0);
        queue_request(KIND_ERASE, 0, 0, 0, 0, 0);
        queue_request(KIND_ERASE, 127, 127, 1, 1, 0);
        queue_request(KIND_REFRESH, 0, 0, 1, 1, 0);
        queue_request(KIND_TOGGLE, 0, 0, 0, 0, 1);
        queue_request(KIND_TOGGLE, 127, 127, 1, 1, 0);
        queue_request(KIND_REFRESH, 0, 85, 1, 1, 0);
        queue_request(KIND_REFRESH, 0, 42, 1, 1, 0);
        queue_request(KIND_CLEAR, 0, 0, 0, 0, 0);
        queue_request(KIND_REFRESH, 0, 127, 1, 1, 0);
        queue_request(KIND_CLEAR, 127, 127, 1, 1, 0);
        queue_request(3'd5, 127, 127, 1, 1, 0);
        queue_request(3'd6, 0, 0, 0, 0, 0);
        queue_request(3'd7, 85, 42, 1, 0, 0);
        queue_request(KIND_REFRESH, 0, 42, 0, 0, 0);
        queue_request(KIND_REFRESH, 0, 42, 1, 1, 0);

        // Random sequences, mostly well-formed transfers
        while (made < TARGET_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            hot = $urandom_range(0, 127);
            if (sel < 45)
            begin
                repeat ($urandom_range(1, 4))
                    queue_request(($urandom_range(0, 3) == 0) ? KIND_ERASE : KIND_DRAW,
                                  $urandom, $urandom_range(0, 1) ? hot : $urandom,
                                  1'($urandom), 1'($urandom), 0);
                lines = $urandom_range(1, 4);
                for (j = 0; j < lines; j++)
                    queue_request(KIND_REFRESH, $urandom,
                                  (j == 0) ? hot : $urandom_range(0, 127),
                                  j == 0, j == lines - 1, 0);
            end
            else if (sel < 60)
                queue_request(KIND_TOGGLE, $urandom, $urandom,
                              1'($urandom), 1'($urandom), 0);
            else if (sel < 68)
                queue_request(KIND_CLEAR, $urandom, $urandom,
                              1'($urandom), 1'($urandom), 0);
            else if (sel < 80)
                queue_request($urandom_range(0, 1) ? KIND_ERASE : KIND_DRAW,
                              $urandom, $urandom, 1'($urandom), 1'($urandom), 0);
            else if (sel < 90)
                queue_request(KIND_REFRESH, $urandom, $urandom,
                              1'($urandom), 1'($urandom), 0);
            else if (sel < 95)
                queue_request(3'($urandom_range(5, 7)), $urandom, $urandom,
                              1'($urandom), 1'($urandom), 0);
            else
                queue_request(KIND_TOGGLE, $urandom, $urandom,
                              1'($urandom), 1'($urandom), 1);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || offering)
            @(negedge clk);
        while (spi_expected.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (spi_expected.size() > 0)
        begin
            failures++;
            $display("%0d bytes never arrived", spi_expected.size());
        end
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
